/* hdl/olrb_pkg.sv */
package olrb_pkg;

	// ring geometry
	localparam int DEPTH  = 2048;
	localparam int AW     = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int FILL_OUT_W = 12;
	localparam int INDEX_W    = 11;

	localparam logic [7:0] CH_NEWLINE = 8'h0a;
	localparam logic [7:0] CH_BAR     = 8'h7c;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DEL     = 8'h7f;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	// decoded transaction handed from front to back
	typedef struct packed {
		logic              is_write;
		logic              is_read;  // read with index in range
		logic [AW-1:0]     addr;
		logic [7:0]        data;
		logic [FILL_W-1:0] fill;
	} cmd_t;

	typedef struct packed {
		logic [7:0]            raw_byte;
		logic [7:0]            export_byte;
		logic                  keep_flag;
		logic                  index_valid;
		logic [FILL_OUT_W-1:0] fill_level;
	} res_t;

	// zero-extend or truncate the fill count to the result width
	function automatic logic [FILL_OUT_W-1:0] fill_out(input logic [FILL_W-1:0] f);
		logic [FILL_W+FILL_OUT_W-1:0] ext;
		ext = {{FILL_OUT_W{1'b0}}, f};
		return ext[FILL_OUT_W-1:0];
	endfunction

endpackage

/* hdl/olrb_front.sv */
module olrb_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  q_full,
	input  logic [1:0]            opcode,
	input  logic [7:0]            data_byte,
	input  logic [10:0]           read_index,
	output logic                  push,
	output olrb_pkg::cmd_t        cmd
);

	localparam logic [olrb_pkg::AW-1:0]     LAST = olrb_pkg::AW'(olrb_pkg::DEPTH - 1);
	localparam logic [olrb_pkg::FILL_W-1:0] FULL = olrb_pkg::FILL_W'(olrb_pkg::DEPTH);
	localparam logic [olrb_pkg::AW:0]       DEP  = (olrb_pkg::AW + 1)'(olrb_pkg::DEPTH);

	logic [olrb_pkg::AW-1:0]     head_q, tail_q, head_d, tail_d;
	logic [olrb_pkg::FILL_W-1:0] fill_q, fill_d;
	logic [olrb_pkg::FILL_W+olrb_pkg::INDEX_W-1:0] idx_cmp, fill_cmp;
	logic [olrb_pkg::AW:0]       pos_sum;
	logic [olrb_pkg::AW-1:0]     pos;
	logic                        in_range;

	assign push = start && !q_full;

	assign idx_cmp  = {{olrb_pkg::FILL_W{1'b0}}, read_index};
	assign fill_cmp = {{olrb_pkg::INDEX_W{1'b0}}, fill_q};
	assign in_range = idx_cmp < fill_cmp;

	// oldest entry plus index, one wrap at most since index < fill <= DEPTH
	assign pos_sum = {1'b0, tail_q} + {1'b0, read_index};
	assign pos     = (pos_sum >= DEP) ? olrb_pkg::AW'(pos_sum - DEP)
	                                  : pos_sum[olrb_pkg::AW-1:0];

	always_comb begin
		head_d       = head_q;
		tail_d       = tail_q;
		fill_d       = fill_q;
		cmd.is_write = 1'b0;
		cmd.is_read  = 1'b0;
		cmd.addr     = pos;
		cmd.data     = data_byte;
		unique case (olrb_pkg::opcode_t'(opcode))
			olrb_pkg::OP_APPEND: begin
				cmd.is_write = 1'b1;
				cmd.addr     = head_q;
				head_d       = (head_q == LAST) ? '0 : head_q + 1'b1;
				if (fill_q == FULL) begin
					tail_d = (tail_q == LAST) ? '0 : tail_q + 1'b1;
				end else begin
					fill_d = fill_q + 1'b1;
				end
			end
			olrb_pkg::OP_CLEAR: begin
				head_d = '0;
				tail_d = '0;
				fill_d = '0;
			end
			olrb_pkg::OP_READ: begin
				cmd.is_read = in_range;
			end
			olrb_pkg::OP_NOP: begin
			end
			default: begin
			end
		endcase
		cmd.fill = fill_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (push) begin
			head_q <= head_d;
			tail_q <= tail_d;
			fill_q <= fill_d;
		end
	end

endmodule

/* hdl/olrb_cmd_fifo.sv */
module olrb_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  olrb_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           pop,
	output olrb_pkg::cmd_t pop_cmd
);

	localparam logic [olrb_pkg::QPTR_W-1:0] QLAST = olrb_pkg::QPTR_W'(olrb_pkg::QDEPTH - 1);
	localparam logic [olrb_pkg::QCNT_W-1:0] QFULL = olrb_pkg::QCNT_W'(olrb_pkg::QDEPTH);

	olrb_pkg::cmd_t              entry_q [olrb_pkg::QDEPTH];
	logic [olrb_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [olrb_pkg::QCNT_W-1:0] cnt_q;

	assign full    = cnt_q == QFULL;
	assign pop     = cnt_q != '0;  // back takes one transaction every cycle while the queue holds one
	assign pop_cmd = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QLAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QLAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/olrb_back.sv */
module olrb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop,
	input  olrb_pkg::cmd_t cmd,
	output logic           done,
	output olrb_pkg::res_t res
);

	logic [7:0]                  ring_q [olrb_pkg::DEPTH];
	logic [7:0]                  rdata_s1;
	logic                        valid_s1, rd_s1;
	logic [olrb_pkg::FILL_W-1:0] fill_s1;
	logic [7:0]                  raw;
	logic                        ctrl;
	logic                        done_q;
	olrb_pkg::res_t              res_q;

	always_ff @(posedge clk) begin
		if (pop && cmd.is_write) begin
			ring_q[cmd.addr] <= cmd.data;
		end
		rdata_s1 <= ring_q[cmd.addr];
		rd_s1    <= cmd.is_read;
		fill_s1  <= cmd.fill;
	end

	assign raw  = rd_s1 ? rdata_s1 : 8'h00;
	assign ctrl = (raw < olrb_pkg::CH_SPACE) || (raw == olrb_pkg::CH_DEL);

	always_ff @(posedge clk) begin
		res_q.raw_byte    <= raw;
		res_q.export_byte <= (raw == olrb_pkg::CH_NEWLINE) ? olrb_pkg::CH_BAR : raw;
		res_q.keep_flag   <= rd_s1 && ((raw == olrb_pkg::CH_NEWLINE) || !ctrl);
		res_q.index_valid <= rd_s1;
		res_q.fill_level  <= olrb_pkg::fill_out(fill_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= pop;
			done_q   <= valid_s1;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

/* hdl/overwriting_log_ring_buffer.sv */
// channel   | signals                                   | handshake
// ----------+-------------------------------------------+----------------------------
// command   | opcode, data_byte, read_index             | taken when start && !busy
// result    | raw_byte, export_byte, keep_flag,         | valid for one cycle with done,
//           | index_valid, fill_level                   | no back-pressure
//
// One transaction per cycle sustained; done and the result pass through the
// queue slot, the ring read register and the format register in turn. The rate
// is set by the single ring port: one write or one read per cycle.
// Reset clears head, tail, fill count, queue state and the valid_s1/done flags;
// ring contents are left as they are and are only read after being written.
// The back end drains the queue every cycle, so the queue never holds more than
// one transaction and busy stays low.
module overwriting_log_ring_buffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	input  logic [10:0] read_index,
	output logic        done,
	output logic [7:0]  raw_byte,
	output logic [7:0]  export_byte,
	output logic        keep_flag,
	output logic        index_valid,
	output logic [11:0] fill_level
);

	logic           push, q_full, pop;
	olrb_pkg::cmd_t push_cmd, pop_cmd;
	olrb_pkg::res_t res;

	// front: accepts the transaction, keeps head/tail/fill and resolves
	// the ring address and range check
	olrb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.q_full     (q_full),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.read_index (read_index),
		.push       (push),
		.cmd        (push_cmd)
	);

	// short queue decouples decode from the ring access
	olrb_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd)
	);

	// back: ring memory access and export formatting
	olrb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.pop    (pop),
		.cmd    (pop_cmd),
		.done   (done),
		.res    (res)
	);

	assign busy        = q_full;
	assign raw_byte    = res.raw_byte;
	assign export_byte = res.export_byte;
	assign keep_flag   = res.keep_flag;
	assign index_valid = res.index_valid;
	assign fill_level  = res.fill_level;

	// a result only follows an accepted transaction, at fixed latency
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result strobe without matching transaction");

	// out-of-range or non-read results carry no byte
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !index_valid |-> raw_byte == 8'h00 && export_byte == 8'h00 && !keep_flag)
		else $error("byte returned without a valid read");

	// a valid index only comes from a read command
	a_valid_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		done && index_valid |-> $past(opcode, 3) == olrb_pkg::OP_READ)
		else $error("index_valid set for a non-read transaction");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Trace ring checker: the sender feeds append/clear/read/idle-op transactions
// from a queue, a local copy of the ring predicts each result at the
// accepting edge, and the monitor checks every done strobe against the
// oldest prediction.
module tb_top;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYC    = 9;
	localparam int STALL_LIMIT  = 1000;  // cycles with no transaction either way
	localparam int TAIL_CYCLES  = 8;     // result is taken after the queue slot, ring read and format registers
	localparam int REPORT_CAP   = 40;    // keep the log short on a broken build
	localparam int QUIET_FROM   = 500;   // sender inserts no random gaps in this window
	localparam int QUIET_TO     = 900;
	localparam int LONG_APPENDS = 600;

	typedef struct packed {
		olrb_pkg::opcode_t            op;
		logic [7:0]                   data;
		logic [olrb_pkg::INDEX_W-1:0] index;
	} trace_cmd_t;

	logic                            clk        = 1'b0;
	logic                            arst_n     = 1'b0;
	logic                            start      = 1'b0;
	logic [1:0]                      opcode     = olrb_pkg::OP_NOP;
	logic [7:0]                      data_byte  = 8'h00;
	logic [olrb_pkg::INDEX_W-1:0]    read_index = '0;
	logic                            busy;
	logic                            done;
	logic [7:0]                      raw_byte;
	logic [7:0]                      export_byte;
	logic                            keep_flag;
	logic                            index_valid;
	logic [olrb_pkg::FILL_OUT_W-1:0] fill_level;

	overwriting_log_ring_buffer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.read_index (read_index),
		.done       (done),
		.raw_byte   (raw_byte),
		.export_byte(export_byte),
		.keep_flag  (keep_flag),
		.index_valid(index_valid),
		.fill_level (fill_level)
	);

	// Local copy of the ring. Only entries written since the last clear are
	// ever read back, so the initial contents never matter.
	logic [7:0]                  ring_copy [olrb_pkg::DEPTH];
	logic [olrb_pkg::AW-1:0]     head_copy = '0;
	logic [olrb_pkg::FILL_W-1:0] fill_copy = '0;

	trace_cmd_t      pending_cmds[$];      // stimulus not yet offered to the block
	olrb_pkg::res_t  expected_results[$];  // predictions waiting for their strobe

	trace_cmd_t     next_cmd;
	olrb_pkg::res_t want;
	bit             sender_gap;
	bit             timed_out = 1'b0;
	int             err_cnt = 0;
	int             stall_cycles = 0;
	int             drive_cycles = 0;
	int             gen_fill = 0;  // fill as the stimulus generator sees it

	// coverage tallies for the summary
	int n_append = 0, n_overwrite = 0, n_clear = 0, n_nop = 0;
	int n_read_hit = 0, n_read_miss = 0, n_newline = 0, n_ctrl = 0;
	int peak_fill = 0, results_seen = 0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= REPORT_CAP)
			$display("[%0t] MISMATCH: %s", $time, msg);
	endtask

	// Apply one accepted transaction to the local ring and queue the result
	// the block should produce for it.
	task automatic predict_transaction(input olrb_pkg::opcode_t op, input logic [7:0] data,
			input logic [olrb_pkg::INDEX_W-1:0] index);
		olrb_pkg::res_t r;
		int             pos;
		r = '0;
		case (op)
			olrb_pkg::OP_APPEND: begin
				ring_copy[head_copy] = data;
				head_copy = (head_copy == olrb_pkg::AW'(olrb_pkg::DEPTH - 1)) ? '0
					: head_copy + 1'b1;
				if (fill_copy < olrb_pkg::FILL_W'(olrb_pkg::DEPTH))
					fill_copy = fill_copy + 1'b1;
				else
					n_overwrite++;  // ring full: oldest byte dropped
				n_append++;
			end
			olrb_pkg::OP_CLEAR: begin
				head_copy = '0;
				fill_copy = '0;
				n_clear++;
			end
			olrb_pkg::OP_READ: begin
				if (index < fill_copy) begin
					// oldest byte sits fill entries behind the head
					pos = (int'(head_copy) + olrb_pkg::DEPTH - int'(fill_copy) +
						int'(index)) % olrb_pkg::DEPTH;
					r.raw_byte    = ring_copy[pos];
					r.index_valid = 1'b1;
					if (r.raw_byte == olrb_pkg::CH_NEWLINE) begin
						r.export_byte = olrb_pkg::CH_BAR;
						r.keep_flag   = 1'b1;
						n_newline++;
					end else begin
						r.export_byte = r.raw_byte;
						r.keep_flag   = !(r.raw_byte < olrb_pkg::CH_SPACE ||
							r.raw_byte == olrb_pkg::CH_DEL);
						if (!r.keep_flag)
							n_ctrl++;
					end
					n_read_hit++;
				end else
					n_read_miss++;
			end
			olrb_pkg::OP_NOP: n_nop++;
		endcase
		r.fill_level = olrb_pkg::FILL_OUT_W'(fill_copy);
		if (int'(fill_copy) > peak_fill)
			peak_fill = int'(fill_copy);
		expected_results.push_back(r);
	endtask

	// Driver: offers the next pending transaction whenever the slot is free,
	// holds it while busy, and drops start for a random gap now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			opcode     <= olrb_pkg::OP_NOP;
			data_byte  <= 8'h00;
			read_index <= '0;
		end else begin
			drive_cycles++;
			if (start && !busy)
				predict_transaction(olrb_pkg::opcode_t'(opcode), data_byte, read_index);
			if (!start || !busy) begin
				sender_gap = (drive_cycles < QUIET_FROM || drive_cycles >= QUIET_TO) &&
					($urandom_range(99) < 10);
				if (pending_cmds.size() != 0 && !sender_gap) begin
					next_cmd    = pending_cmds.pop_front();
					start      <= 1'b1;
					opcode     <= next_cmd.op;
					data_byte  <= next_cmd.data;
					read_index <= next_cmd.index;
				end else
					start <= 1'b0;
			end
		end
	end

	// Monitor: every done strobe must match the oldest prediction field by
	// field. Also keeps the watchdog count of cycles with no traffic.
	always @(posedge clk) begin
		if (!arst_n)
			stall_cycles <= 0;
		else begin
			if (done) begin
				results_seen++;
				if (expected_results.size() == 0)
					report_mismatch($sformatf("result with nothing outstanding: raw %02h fill %0d",
						raw_byte, fill_level));
				else begin
					want = expected_results.pop_front();
					if (raw_byte !== want.raw_byte)
						report_mismatch($sformatf("raw_byte %02h, expected %02h",
							raw_byte, want.raw_byte));
					if (export_byte !== want.export_byte)
						report_mismatch($sformatf("export_byte %02h, expected %02h",
							export_byte, want.export_byte));
					if (keep_flag !== want.keep_flag)
						report_mismatch($sformatf("keep_flag %b, expected %b (raw %02h)",
							keep_flag, want.keep_flag, want.raw_byte));
					if (index_valid !== want.index_valid)
						report_mismatch($sformatf("index_valid %b, expected %b",
							index_valid, want.index_valid));
					if (fill_level !== want.fill_level)
						report_mismatch($sformatf("fill_level %0d, expected %0d",
							fill_level, want.fill_level));
				end
			end
			stall_cycles <= (done || (start && !busy)) ? 0 : stall_cycles + 1;
		end
	end

	task automatic queue_cmd(input olrb_pkg::opcode_t op, input logic [7:0] data,
			input logic [olrb_pkg::INDEX_W-1:0] index);
		trace_cmd_t c;
		c.op    = op;
		c.data  = data;
		c.index = index;
		pending_cmds.push_back(c);
		if (op == olrb_pkg::OP_APPEND && gen_fill < olrb_pkg::DEPTH)
			gen_fill++;
		else if (op == olrb_pkg::OP_CLEAR)
			gen_fill = 0;
	endtask

	// Trace bytes lean toward the characters the export form treats specially.
	function automatic logic [7:0] pick_trace_byte();
		logic [7:0] specials [9];
		specials = '{8'h00, olrb_pkg::CH_NEWLINE, 8'h1f, olrb_pkg::CH_SPACE,
			olrb_pkg::CH_BAR, 8'h7e, olrb_pkg::CH_DEL, 8'h80, 8'hff};
		if ($urandom_range(99) < 30)
			return specials[$urandom_range(8)];
		return 8'($urandom);
	endfunction

	// Mostly in-range indexes; some at the edges and some anywhere.
	function automatic logic [olrb_pkg::INDEX_W-1:0] pick_read_index();
		int r;
		r = $urandom_range(99);
		if (gen_fill == 0 || r < 12)
			return olrb_pkg::INDEX_W'($urandom);
		if (r < 18)
			return '0;
		if (r < 24)
			return olrb_pkg::INDEX_W'(gen_fill - 1);
		if (r < 30)
			return olrb_pkg::INDEX_W'(gen_fill);  // just past the end unless full
		return olrb_pkg::INDEX_W'($urandom_range(gen_fill - 1));
	endfunction

	task automatic queue_random_cmd(input int append_pct, input int clear_pct);
		int r;
		r = $urandom_range(99);
		if (r < append_pct)
			queue_cmd(olrb_pkg::OP_APPEND, pick_trace_byte(), olrb_pkg::INDEX_W'($urandom));
		else if (r < append_pct + clear_pct)
			queue_cmd(olrb_pkg::OP_CLEAR, 8'($urandom), olrb_pkg::INDEX_W'($urandom));
		else if (r < append_pct + clear_pct + 2)
			queue_cmd(olrb_pkg::OP_NOP, 8'($urandom), olrb_pkg::INDEX_W'($urandom));
		else
			queue_cmd(olrb_pkg::OP_READ, 8'($urandom), pick_read_index());
	endtask

	initial begin
		logic [7:0] first_bytes [8];
		int         long_appends;
		first_bytes = '{8'h00, olrb_pkg::CH_NEWLINE, 8'h1f, olrb_pkg::CH_SPACE, 8'h7e,
			olrb_pkg::CH_DEL, olrb_pkg::CH_BAR, 8'hff};

		// Directed: empty ring, idle op, every export class, both range edges,
		// and a clear followed by a fresh byte.
		queue_cmd(olrb_pkg::OP_READ, 8'h5a, '0);
		queue_cmd(olrb_pkg::OP_NOP, 8'ha5, olrb_pkg::INDEX_W'(2047));
		foreach (first_bytes[i])
			queue_cmd(olrb_pkg::OP_APPEND, first_bytes[i], olrb_pkg::INDEX_W'($urandom));
		for (int i = 0; i < 8; i++)
			queue_cmd(olrb_pkg::OP_READ, 8'hff, olrb_pkg::INDEX_W'(i));
		queue_cmd(olrb_pkg::OP_READ, 8'h00, olrb_pkg::INDEX_W'(8));
		queue_cmd(olrb_pkg::OP_READ, 8'h00, olrb_pkg::INDEX_W'(2047));
		queue_cmd(olrb_pkg::OP_CLEAR, 8'hff, olrb_pkg::INDEX_W'(2047));
		queue_cmd(olrb_pkg::OP_READ, 8'h00, '0);
		queue_cmd(olrb_pkg::OP_APPEND, 8'h41, '0);
		queue_cmd(olrb_pkg::OP_READ, 8'h00, '0);

		// Short traces, about half starting from a cleared ring.
		repeat (20) begin
			if ($urandom_range(1))
				queue_cmd(olrb_pkg::OP_CLEAR, 8'($urandom), olrb_pkg::INDEX_W'($urandom));
			repeat ($urandom_range(10, 40))
				queue_random_cmd(60, 3);
		end

		// One long trace with reads scattered through it so the upper index
		// bits are hit.
		queue_cmd(olrb_pkg::OP_CLEAR, 8'($urandom), olrb_pkg::INDEX_W'($urandom));
		long_appends = 0;
		while (long_appends < LONG_APPENDS) begin
			if ($urandom_range(99) < 88) begin
				queue_cmd(olrb_pkg::OP_APPEND, pick_trace_byte(),
					olrb_pkg::INDEX_W'($urandom));
				long_appends++;
			end else
				queue_cmd(olrb_pkg::OP_READ, 8'($urandom), pick_read_index());
		end

		// Read-heavy tail on the long trace, then more mixed traffic.
		repeat (60)
			queue_random_cmd(30, 0);
		repeat (80)
			queue_random_cmd(55, 4);

		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!timed_out && !(pending_cmds.size() == 0 && !start &&
				expected_results.size() == 0)) begin
			@(negedge clk);
			if (stall_cycles >= STALL_LIMIT)
				timed_out = 1'b1;
		end
		if (!timed_out)
			repeat (TAIL_CYCLES) @(negedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (timed_out)
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);

		$display("Covered %0d appends (%0d overwriting), %0d clears, %0d idle ops, peak fill %0d",
			n_append, n_overwrite, n_clear, n_nop, peak_fill);
		$display("Reads: %0d in range (%0d newline, %0d control), %0d out of range; %0d results",
			n_read_hit, n_newline, n_ctrl, n_read_miss, results_seen);

		if (!timed_out && err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
